FILE: hw/rtl/mrb_pkg.sv
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared types and constants of the mailbox register block: address map,
// operation codes, register kinds and the command and result words.
// ----------------------------------------------------------------------------
package mrb_pkg;

	// block size
	localparam int NumChannels     = 4;
	localparam int WordsPerChannel = 8;
	localparam int RemoteLines     = 3;
	localparam int ChanWindowBytes = 4096;
	localparam int Remote0RegBase  = 16384;

	// derived widths
	localparam int ChanW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
	localparam int RegW  = $clog2(ChanWindowBytes);
	localparam int IdxW  = (WordsPerChannel > 1) ? $clog2(WordsPerChannel) : 1;
	localparam int LineW = RemoteLines;
	localparam int GenW  = 8;

	// window geometry
	localparam logic [16:0] LocalLimit  = 17'(NumChannels * ChanWindowBytes);
	localparam logic [16:0] WindowSpan  = 17'(ChanWindowBytes);
	localparam logic [15:0] Remote0Base = 16'(Remote0RegBase);

	// register offsets inside a channel window
	localparam logic [RegW-1:0] OfsStatus    = RegW'(32'h000);
	localparam logic [RegW-1:0] OfsClear     = RegW'(32'h004);
	localparam logic [RegW-1:0] OfsMask      = RegW'(32'h00c);
	localparam logic [RegW-1:0] OfsGenerate  = RegW'(32'h010);
	localparam logic [RegW-1:0] OfsInfoFirst = RegW'(32'h014);
	localparam logic [RegW-1:0] OfsInfoLast  = RegW'(32'h014 + 4 * (WordsPerChannel - 1));

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_EVENT = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_NONE,
		REG_STATUS,
		REG_CLEAR,
		REG_MASK,
		REG_GENERATE,
		REG_INFO
	} reg_kind_t;

	// decoded access, handed from the address decoder to the register file
	typedef struct packed {
		reg_kind_t            kind;
		logic [ChanW-1:0]     chan;
		logic [IdxW-1:0]      idx;
	} dec_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  window;
		logic [15:0] byte_offset;
		logic [31:0] write_data;
		logic [1:0]  event_line;
		logic        event_level;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        access_error;
	} result_t;

endpackage

FILE: hw/rtl/mrb_decode.sv
// ----------------------------------------------------------------------------
// mrb_decode
// Address decoder: window and byte offset to channel, register kind and
// info word index.
// ----------------------------------------------------------------------------
module mrb_decode (
	input  logic [1:0]    window,
	input  logic [15:0]   byte_offset,
	output mrb_pkg::dec_t dec
);

	logic                     hit;
	logic [15:0]              base;
	logic [15:0]              rel;
	logic [mrb_pkg::RegW-1:0] reg_ofs;
	logic [mrb_pkg::RegW-1:0] info_rel;

	always_comb begin
		base = (window == 2'd1) ? mrb_pkg::Remote0Base : 16'd0;
		rel  = byte_offset - base;
		if (window == 2'd0) begin
			// local window: channel windows back to back
			hit      = {1'b0, byte_offset} < mrb_pkg::LocalLimit;
			dec.chan = mrb_pkg::ChanW'(byte_offset >> mrb_pkg::RegW);
			reg_ofs  = byte_offset[mrb_pkg::RegW-1:0];
		end else begin
			hit = (32'(window) < mrb_pkg::NumChannels) && (byte_offset >= base) &&
				({1'b0, byte_offset} < ({1'b0, base} + mrb_pkg::WindowSpan));
			dec.chan = mrb_pkg::ChanW'(window);
			reg_ofs  = rel[mrb_pkg::RegW-1:0];
		end

		info_rel = reg_ofs - mrb_pkg::OfsInfoFirst;
		dec.idx  = mrb_pkg::IdxW'(info_rel >> 2);

		if (!hit)
			dec.kind = mrb_pkg::REG_NONE;
		else if (reg_ofs == mrb_pkg::OfsStatus)
			dec.kind = mrb_pkg::REG_STATUS;
		else if (reg_ofs == mrb_pkg::OfsClear)
			dec.kind = mrb_pkg::REG_CLEAR;
		else if (reg_ofs == mrb_pkg::OfsMask)
			dec.kind = mrb_pkg::REG_MASK;
		else if (reg_ofs == mrb_pkg::OfsGenerate)
			dec.kind = mrb_pkg::REG_GENERATE;
		else if (reg_ofs >= mrb_pkg::OfsInfoFirst && reg_ofs <= mrb_pkg::OfsInfoLast)
			dec.kind = mrb_pkg::REG_INFO;
		else
			dec.kind = mrb_pkg::REG_NONE;
	end

endmodule

FILE: hw/rtl/mrb_regs.sv
// ----------------------------------------------------------------------------
// mrb_regs
// Register file: info words, generate registers, event status and mask.
// Applies one decoded word per cycle and forms its result.
// ----------------------------------------------------------------------------
module mrb_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  mrb_pkg::cmd_t   cmd,
	input  mrb_pkg::dec_t   dec,
	output mrb_pkg::result_t res
);

	logic [31:0]               info_q [mrb_pkg::NumChannels][mrb_pkg::WordsPerChannel];
	logic [mrb_pkg::GenW-1:0]  gen_q  [mrb_pkg::NumChannels];
	logic [mrb_pkg::LineW-1:0] status_q;
	logic [mrb_pkg::LineW-1:0] mask_q;
	logic [mrb_pkg::LineW-1:0] status_d;
	logic [mrb_pkg::LineW-1:0] mask_d;

	logic is_rd;
	logic is_wr;
	logic is_ev;
	logic chan0;

	always_comb begin
		is_rd = valid && (cmd.op == mrb_pkg::OP_READ);
		is_wr = valid && (cmd.op == mrb_pkg::OP_WRITE);
		is_ev = valid && (cmd.op == mrb_pkg::OP_EVENT);
		chan0 = (dec.chan == '0);

		status_d = status_q;
		mask_d   = mask_q;
		for (int i = 0; i < mrb_pkg::LineW; i++) begin
			if (is_ev && cmd.event_level && (32'(cmd.event_line) == i))
				status_d[i] = 1'b1;
		end
		if (is_wr && chan0 && dec.kind == mrb_pkg::REG_CLEAR)
			status_d = status_q & ~cmd.write_data[mrb_pkg::LineW-1:0];
		if (is_wr && chan0 && dec.kind == mrb_pkg::REG_MASK)
			mask_d = cmd.write_data[mrb_pkg::LineW-1:0];

		res.read_data = 32'd0;
		if (is_rd) begin
			case (dec.kind)
				mrb_pkg::REG_STATUS:   res.read_data = chan0 ? 32'(status_q) : 32'd0;
				mrb_pkg::REG_MASK:     res.read_data = chan0 ? 32'(mask_q) : 32'd0;
				mrb_pkg::REG_GENERATE: res.read_data = 32'(gen_q[dec.chan]);
				mrb_pkg::REG_INFO:     res.read_data = info_q[dec.chan][dec.idx];
				default:               res.read_data = 32'd0;
			endcase
		end

		res.access_error = (is_rd || is_wr) && ((dec.kind == mrb_pkg::REG_NONE) ||
			(is_wr && dec.kind == mrb_pkg::REG_STATUS));
		res.irq_level    = |(status_d & mask_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			mask_q   <= '0;
			for (int c = 0; c < mrb_pkg::NumChannels; c++) begin
				gen_q[c] <= '0;
				for (int w = 0; w < mrb_pkg::WordsPerChannel; w++)
					info_q[c][w] <= '0;
			end
		end else begin
			status_q <= status_d;
			mask_q   <= mask_d;
			if (is_wr && dec.kind == mrb_pkg::REG_GENERATE)
				gen_q[dec.chan] <= cmd.write_data[mrb_pkg::GenW-1:0];
			if (is_wr && dec.kind == mrb_pkg::REG_INFO)
				info_q[dec.chan][dec.idx] <= cmd.write_data;
		end
	end

endmodule

FILE: hw/rtl/mailbox_register_block.sv
// ----------------------------------------------------------------------------
// mailbox_register_block
// Interprocessor mailbox: per-channel generate register and info words,
// remote event status with write-one-to-clear and mask, level interrupt.
// ----------------------------------------------------------------------------
//
//  channel   | signals                  | handshake
//  ----------+--------------------------+-------------------------------------
//  command   | start, busy, cmd         | word taken when start && !busy
//  result    | done, result             | one-cycle strobe, cannot be held off
//
//  one word per cycle; every command word gives exactly one result word
//  the result strobe comes out of the result register after the command is taken
//  (input register, then decode + register update into the result register)
//  busy is always low: the register file never holds off a word
//  asynchronous reset clears info words, generate registers, status, mask and pipeline valids
//  the receiver has no stall; results simply stream out behind the commands
//
module mailbox_register_block (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mrb_pkg::cmd_t    cmd,
	output logic             done,
	output mrb_pkg::result_t result
);

	// input register
	logic             valid_s1;
	mrb_pkg::cmd_t    cmd_s1;

	// result register
	logic             done_s2;
	mrb_pkg::result_t result_s2;

	mrb_pkg::dec_t    dec;
	mrb_pkg::result_t res;

	// never stalls: a new word may enter every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (start && !busy)
			cmd_s1 <= cmd;
		if (valid_s1)
			result_s2 <= res;
	end

	// window / offset decode of the registered command
	mrb_decode u_decode (
		.window      (cmd_s1.window),
		.byte_offset (cmd_s1.byte_offset),
		.dec         (dec)
	);

	// register file: state updates at the end of stage one, so the next word
	// in the input register already sees them
	mrb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.cmd    (cmd_s1),
		.dec    (dec),
		.res    (res)
	);

	assign done   = done_s2;
	assign result = result_s2;

endmodule
